// ===== hdl/mt_pkg.sv =====
// Package for the MT19937 generator: constants, operation codes and the
// command/status structs between controller and datapath. No dependencies.
package mt_pkg;

    localparam int unsigned N_WORDS = 624;
    localparam int unsigned M_SHIFT = 397;

    localparam logic [31:0] TWIST_POLY = 32'h9908b0df;
    localparam logic [31:0] TEMPER_B   = 32'h9d2c5680;
    localparam logic [31:0] TEMPER_C   = 32'hefc60000;
    localparam logic [31:0] INIT_MUL   = 32'd1812433253;
    localparam logic [31:0] ARR_MUL1   = 32'd1664525;
    localparam logic [31:0] ARR_MUL2   = 32'd1566083941;
    localparam logic [31:0] ARR_SEED   = 32'd19650218;
    localparam logic [31:0] DEF_SEED   = 32'd5489;
    localparam logic [31:0] HI_BIT     = 32'h80000000;
    localparam logic [31:0] LO_BITS    = 32'h7fffffff;

    localparam logic [1:0] OP_DRAW = 2'd0;
    localparam logic [1:0] OP_SEED = 2'd1;
    localparam logic [1:0] OP_KEY  = 2'd2;

    // datapath step kinds
    typedef enum logic [2:0] {
        DP_NONE  = 3'd0,
        DP_INIT  = 3'd1,  // single-word init step
        DP_ARR1  = 3'd2,  // array init, key pass
        DP_ARR2  = 3'd3,  // array init, mixing pass
        DP_TWIST = 3'd4,  // twist one word
        DP_DRAW  = 3'd5   // read and temper
    } dp_op_t;

    typedef struct packed {
        dp_op_t            op;
        logic              start;   // load seed word / prime for a pass
        logic [31:0]       seed;
    } dp_cmd_t;

    typedef struct packed {
        logic              busy;    // a multi-cycle step is in flight
        logic              done;    // the pass has finished
    } dp_sts_t;

endpackage

// ===== hdl/mt_datapath.sv =====
// Datapath of the MT19937 generator: state memory, key store, one multiply
// per step and the tempering stage. Depends on mt_pkg.
module mt_datapath #(
    parameter int unsigned KEY_MAX = 8,
    parameter int unsigned KEY_W   = 3
) (
    input  logic             clk,
    input  logic             rst_n,
    input  mt_pkg::dp_cmd_t  cmd,
    input  logic             key_we,
    input  logic [KEY_W-1:0] key_wa,
    input  logic [31:0]      key_wd,
    input  logic [KEY_W:0]   key_cnt,
    input  logic [9:0]       draw_idx,
    output mt_pkg::dp_sts_t  sts,
    output logic [31:0]      word
);

    // state memory, one write and one registered read port per cycle
    logic [31:0] mem [mt_pkg::N_WORDS];
    logic [31:0] keys [KEY_MAX];

    // pass sequencing: each step runs through the phases counted in ph_reg,
    // per kind of step (init, array plus a phase for the wrap copy, twist)
    logic [2:0]  ph_reg, ph_next;
    logic [9:0]  i_reg, i_next;
    logic [KEY_W-1:0] j_reg, j_next;
    logic [10:0] k_reg, k_next;
    logic        run_reg, run_next;
    logic        done_reg, done_next;
    logic [31:0] prev_reg, prev_next;   // previous word (last written)
    logic [31:0] a_reg, a_next;         // word being updated / upper word
    logic [31:0] b_reg, b_next;         // far word
    logic [31:0] c_reg, c_next;         // next word
    logic [31:0] prod_reg;
    logic [31:0] rd_reg;
    logic [9:0]  ra;
    logic        we;
    logic [9:0]  wa;
    logic [31:0] wd;
    logic [31:0] mul_a, mul_b;
    logic [31:0] x;
    logic [KEY_W:0] cnt_eff;
    logic [10:0] steps;
    logic [31:0] y, t;

    always_comb
    begin
        if (key_cnt == '0)
            cnt_eff = (KEY_W+1)'(1);
        else
            cnt_eff = key_cnt;
        steps = 11'(mt_pkg::N_WORDS);
    end

    always_comb
    begin
        x = prev_reg ^ (prev_reg >> 30);
        case (cmd.op)
            mt_pkg::DP_INIT: mul_b = mt_pkg::INIT_MUL;
            mt_pkg::DP_ARR1: mul_b = mt_pkg::ARR_MUL1;
            default:         mul_b = mt_pkg::ARR_MUL2;
        endcase
        mul_a = x;
    end

    always_comb
    begin
        ph_next = ph_reg; i_next = i_reg; j_next = j_reg; k_next = k_reg;
        run_next = run_reg; done_next = 1'b0; prev_next = prev_reg;
        a_next = a_reg; b_next = b_reg; c_next = c_reg;
        ra = i_reg; we = 1'b0; wa = i_reg; wd = '0; y = '0;
        if (cmd.start) begin
            run_next = 1'b1; ph_next = '0; j_next = '0;
            case (cmd.op)
                mt_pkg::DP_INIT: begin
                    we = 1'b1; wa = '0; wd = cmd.seed; prev_next = cmd.seed;
                    i_next = 10'd1; k_next = 11'(mt_pkg::N_WORDS - 1);
                end
                mt_pkg::DP_ARR1: begin
                    // word 0 holds the array base seed
                    i_next = 10'd1; k_next = steps; prev_next = mt_pkg::ARR_SEED;
                end
                mt_pkg::DP_ARR2: begin
                    k_next = 11'(mt_pkg::N_WORDS - 1);
                end
                mt_pkg::DP_TWIST: begin
                    i_next = '0; k_next = 11'(mt_pkg::N_WORDS);
                end
                default: run_next = 1'b0;
            endcase
        end else if (run_reg) begin
            case (cmd.op)
                mt_pkg::DP_INIT: begin
                    // phase0: mul launched on prev; phase1: write
                    if (ph_reg == 3'd0) ph_next = 3'd1;
                    else begin
                        we = 1'b1; wd = prod_reg + 32'(i_reg); prev_next = wd;
                        ph_next = 3'd0; i_next = i_reg + 10'd1; k_next = k_reg - 11'd1;
                        if (k_reg == 11'd1) begin run_next = 1'b0; done_next = 1'b1; end
                    end
                end
                mt_pkg::DP_ARR1, mt_pkg::DP_ARR2: begin
                    // phase0: read mem[i] and mul; phase1: wait; phase2: write;
                    // phase3: copy last word to word 0 after a wrap
                    ra = i_reg;
                    if (ph_reg == 3'd0) ph_next = 3'd1;
                    else if (ph_reg == 3'd1) ph_next = 3'd2;
                    else if (ph_reg == 3'd3) begin
                        we = 1'b1; wa = '0; wd = prev_reg;
                        ph_next = 3'd0;
                        if (k_reg == 11'd0) begin
                            run_next = 1'b0; done_next = 1'b1;
                        end
                    end else begin
                        we = 1'b1;
                        if (cmd.op == mt_pkg::DP_ARR1)
                            wd = (rd_reg ^ prod_reg) + keys[j_reg] + 32'(j_reg);
                        else
                            wd = (rd_reg ^ prod_reg) - 32'(i_reg);
                        prev_next = wd; ph_next = 3'd0; k_next = k_reg - 11'd1;
                        if (cmd.op == mt_pkg::DP_ARR1) begin
                            if ((KEY_W+1)'(j_reg) + 1'b1 >= cnt_eff) j_next = '0;
                            else j_next = j_reg + 1'b1;
                        end
                        if (i_reg == 10'(mt_pkg::N_WORDS - 1)) begin
                            ph_next = 3'd3;
                            i_next = 10'd1;
                        end else begin
                            i_next = i_reg + 10'd1;
                            if (k_reg == 11'd1) begin
                                run_next = 1'b0; done_next = 1'b1;
                            end
                        end
                    end
                end
                mt_pkg::DP_TWIST: begin
                    // ph0 read i, ph1 read i+1, ph2 read far, ph3 latch, ph4 write
                    case (ph_reg)
                        3'd0: begin ra = i_reg; ph_next = 3'd1; end
                        3'd1: begin
                            a_next = rd_reg;
                            ra = (i_reg == 10'(mt_pkg::N_WORDS - 1)) ? '0 : i_reg + 10'd1;
                            ph_next = 3'd2;
                        end
                        3'd2: begin
                            c_next = rd_reg;
                            ra = (i_reg >= 10'(mt_pkg::N_WORDS - mt_pkg::M_SHIFT))
                                 ? i_reg - 10'(mt_pkg::N_WORDS - mt_pkg::M_SHIFT)
                                 : i_reg + 10'(mt_pkg::M_SHIFT);
                            ph_next = 3'd3;
                        end
                        3'd3: begin
                            b_next = rd_reg;
                            ph_next = 3'd4;
                        end
                        default: begin
                            y = (a_reg & mt_pkg::HI_BIT) | (c_reg & mt_pkg::LO_BITS);
                            we = 1'b1;
                            wd = b_reg ^ (y >> 1) ^ (y[0] ? mt_pkg::TWIST_POLY : 32'd0);
                            ph_next = 3'd0; i_next = i_reg + 10'd1; k_next = k_reg - 11'd1;
                            if (k_reg == 11'd1) begin run_next = 1'b0; done_next = 1'b1; end
                        end
                    endcase
                end
                default: run_next = 1'b0;
            endcase
        end else begin
            ra = draw_idx;
        end
    end

    // the copy phase of the array passes also needs the k==0 exit when the
    // wrap falls on the final step
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            run_reg <= 1'b0; done_reg <= 1'b0; ph_reg <= '0;
        end else begin
            run_reg <= run_next; done_reg <= done_next; ph_reg <= ph_next;
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg <= i_next; j_reg <= j_next; k_reg <= k_next;
        prev_reg <= prev_next; a_reg <= a_next; b_reg <= b_next; c_reg <= c_next;
        prod_reg <= mul_a * mul_b;
        if (we) mem[wa] <= wd;
        rd_reg <= mem[ra];
        if (key_we) keys[key_wa] <= key_wd;
    end

    // tempering of the registered read word
    always_comb
    begin
        t = rd_reg;
        t = t ^ (t >> 11);
        t = t ^ ((t << 7) & mt_pkg::TEMPER_B);
        t = t ^ ((t << 15) & mt_pkg::TEMPER_C);
        t = t ^ (t >> 18);
        word = t;
    end

    assign sts.busy = run_reg;
    assign sts.done = done_reg;

endmodule

// ===== hdl/mt_control.sv =====
// Controller of the MT19937 generator: accepts transactions, sequences
// seeding, twisting and drawing, holds the word index and key count.
// Depends on mt_pkg.
module mt_control #(
    parameter int unsigned KEY_MAX = 8,
    parameter int unsigned KEY_W   = 3
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [1:0]       in_op,
    input  logic [31:0]      in_value,
    input  logic             in_last,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [31:0]      out_word,
    output mt_pkg::dp_cmd_t  cmd,
    output logic             key_we,
    output logic [KEY_W-1:0] key_wa,
    output logic [31:0]      key_wd,
    output logic [KEY_W:0]   key_cnt,
    output logic [9:0]       draw_idx,
    input  mt_pkg::dp_sts_t  sts,
    input  logic [31:0]      word
);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b00000001,
        S_INIT  = 8'b00000010,
        S_ARR1  = 8'b00000100,
        S_ARR2  = 8'b00001000,
        S_FIX0  = 8'b00010000,
        S_TWIST = 8'b00100000,
        S_READ  = 8'b01000000,
        S_TEMP  = 8'b10000000
    } state_t;

    state_t          state_reg, state_next;
    logic [9:0]      idx_reg, idx_next;
    logic [KEY_W:0]  cnt_reg, cnt_next;
    logic            arr_reg, arr_next;   // init is part of array seeding
    logic            drw_reg, drw_next;   // seeding on behalf of a draw
    logic            ov_reg, ov_next;
    logic [31:0]     ow_reg, ow_next;
    logic            acc;

    assign in_ready = (state_reg == S_IDLE);
    assign acc      = in_valid && in_ready;
    assign out_valid = ov_reg;
    assign out_word  = ow_reg;
    assign key_cnt   = cnt_reg;
    assign draw_idx  = idx_reg;
    assign key_wa    = cnt_reg[KEY_W-1:0];
    assign key_wd    = in_value;
    assign key_we    = acc && (in_op == mt_pkg::OP_KEY) && (cnt_reg < (KEY_W+1)'(KEY_MAX));

    always_comb
    begin
        state_next = state_reg; idx_next = idx_reg; cnt_next = cnt_reg;
        arr_next = arr_reg; drw_next = drw_reg;
        ov_next = ov_reg; ow_next = ow_reg;
        cmd.op = mt_pkg::DP_NONE; cmd.start = 1'b0; cmd.seed = in_value;
        if (ov_reg && out_ready) ov_next = 1'b0;
        case (state_reg)
            S_IDLE: begin
                if (acc) begin
                    case (in_op)
                        mt_pkg::OP_DRAW: begin
                            if (idx_reg == 10'(mt_pkg::N_WORDS + 1)) begin
                                cmd.op = mt_pkg::DP_INIT; cmd.start = 1'b1;
                                cmd.seed = mt_pkg::DEF_SEED;
                                arr_next = 1'b0; drw_next = 1'b1; state_next = S_INIT;
                            end else if (idx_reg == 10'(mt_pkg::N_WORDS)) begin
                                cmd.op = mt_pkg::DP_TWIST; cmd.start = 1'b1;
                                state_next = S_TWIST;
                            end else
                                state_next = S_READ;
                        end
                        mt_pkg::OP_SEED: begin
                            cmd.op = mt_pkg::DP_INIT; cmd.start = 1'b1;
                            arr_next = 1'b0; drw_next = 1'b0; state_next = S_INIT;
                        end
                        mt_pkg::OP_KEY: begin
                            if (cnt_reg < (KEY_W+1)'(KEY_MAX)) cnt_next = cnt_reg + 1'b1;
                            if (in_last) begin
                                cmd.op = mt_pkg::DP_INIT; cmd.start = 1'b1;
                                cmd.seed = mt_pkg::ARR_SEED;
                                arr_next = 1'b1; drw_next = 1'b0; state_next = S_INIT;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_INIT: begin
                cmd.op = mt_pkg::DP_INIT;
                if (sts.done) begin
                    idx_next = 10'(mt_pkg::N_WORDS);
                    if (arr_reg) begin
                        cmd.op = mt_pkg::DP_ARR1; cmd.start = 1'b1; state_next = S_ARR1;
                    end else if (drw_reg) begin
                        cmd.op = mt_pkg::DP_TWIST; cmd.start = 1'b1; state_next = S_TWIST;
                    end else
                        state_next = S_IDLE;
                end
            end
            S_ARR1: begin
                cmd.op = mt_pkg::DP_ARR1;
                if (sts.done) begin
                    cmd.op = mt_pkg::DP_ARR2; cmd.start = 1'b1; state_next = S_ARR2;
                end
            end
            S_ARR2: begin
                cmd.op = mt_pkg::DP_ARR2;
                if (sts.done) state_next = S_FIX0;
            end
            S_FIX0: begin
                // word 0 forced to the high bit, done through a one-word init
                cmd.op = mt_pkg::DP_INIT; cmd.start = 1'b1; cmd.seed = mt_pkg::HI_BIT;
                cnt_next = '0; idx_next = 10'(mt_pkg::N_WORDS);
                state_next = S_IDLE;
            end
            S_TWIST: begin
                cmd.op = mt_pkg::DP_TWIST;
                if (sts.done) begin idx_next = '0; state_next = S_READ; end
            end
            S_READ: state_next = S_TEMP;
            default: begin
                // hold the read word until the output register is free
                if (!ov_reg || out_ready) begin
                    ov_next = 1'b1; ow_next = word; idx_next = idx_reg + 10'd1;
                    state_next = S_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= S_IDLE; idx_reg <= 10'(mt_pkg::N_WORDS + 1); cnt_reg <= '0;
            arr_reg <= 1'b0; drw_reg <= 1'b0; ov_reg <= 1'b0;
        end else begin
            state_reg <= state_next; idx_reg <= idx_next; cnt_reg <= cnt_next;
            arr_reg <= arr_next; drw_reg <= drw_next; ov_reg <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ow_reg <= ow_next;
    end

`ifndef SYNTHESIS
    a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= (KEY_W+1)'(KEY_MAX)) else $error("key count overflow");
    a_idx: assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg <= 10'(mt_pkg::N_WORDS + 1)) else $error("word index out of range");
    a_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_READ) |-> (idx_reg < 10'(mt_pkg::N_WORDS)))
        else $error("draw from exhausted block");
    a_out: assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && !out_ready) |=> (ov_reg && $stable(ow_reg)))
        else $error("result overwritten");
`endif

endmodule

// ===== hdl/mt19937_generator.sv =====
// MT19937 generator: a draw from a word ready in the state memory passes
// through the states S_READ and S_TEMP before m_tvalid rises; S_TEMP waits
// while the output register is still full, and a new draw is taken once the
// word has moved into it. Seeding and twisting are paced by the single read
// port and the registered multiplier, and no input is taken meanwhile.
// Reset (rst_n low, asynchronous) marks the generator unseeded and empties
// the key store; the state memory itself is not cleared.
module mt19937_generator #(
    parameter int unsigned KEY_MAX = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // operation[1:0], value[33:2], zeros[39:34]
    input  logic        s_tlast,   // last_key
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // random_word[31:0]
);

    localparam int unsigned KEY_W = (KEY_MAX > 1) ? $clog2(KEY_MAX) : 1;

    mt_pkg::dp_cmd_t  cmd;
    mt_pkg::dp_sts_t  sts;
    logic             key_we;
    logic [KEY_W-1:0] key_wa;
    logic [31:0]      key_wd;
    logic [KEY_W:0]   key_cnt;
    logic [9:0]       draw_idx;
    logic [31:0]      word;

    mt_control #(.KEY_MAX(KEY_MAX), .KEY_W(KEY_W)) u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_tvalid), .in_ready(s_tready),
        .in_op(s_tdata[1:0]), .in_value(s_tdata[33:2]), .in_last(s_tlast),
        .out_valid(m_tvalid), .out_ready(m_tready), .out_word(m_tdata),
        .cmd(cmd), .key_we(key_we), .key_wa(key_wa), .key_wd(key_wd),
        .key_cnt(key_cnt), .draw_idx(draw_idx), .sts(sts), .word(word)
    );

    mt_datapath #(.KEY_MAX(KEY_MAX), .KEY_W(KEY_W)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd),
        .key_we(key_we), .key_wa(key_wa), .key_wd(key_wd), .key_cnt(key_cnt),
        .draw_idx(draw_idx), .sts(sts), .word(word)
    );

endmodule

// ===== sim/mt19937_checker.sv =====
// Checker for mt19937_generator: watches both stream channels, keeps its own
// MT19937 state and compares every returned word with the predicted one.
// Depends on mt_pkg for the operation codes.
`timescale 1ns / 1ps

module mt19937_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [39:0] s_tdata,
    input  logic        s_tlast,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,
    output int          errors,
    output int          pending
);

    localparam int unsigned NW       = 624;
    localparam int unsigned KEY_SLOTS = 8;
    localparam int unsigned UNSEEDED = NW + 1;

    logic [31:0] mt_state [NW];
    int unsigned mt_pos;
    logic [31:0] key_words [KEY_SLOTS];
    int unsigned key_n;
    logic [31:0] words_due [$];

    function void init_single(input logic [31:0] s);
        logic [31:0] p;
        mt_state[0] = s;
        for (int unsigned n = 1; n < NW; n++)
        begin
            p = mt_state[n - 1];
            mt_state[n] = 32'd1812433253 * (p ^ (p >> 30)) + n;
        end
        mt_pos = NW;
    endfunction

    function void init_from_key(input int unsigned cnt);
        int unsigned i;
        int unsigned j;
        int unsigned steps;
        logic [31:0] p;
        logic [31:0] mix;
        i = 1;
        j = 0;
        steps = (cnt > NW) ? cnt : NW;
        init_single(32'd19650218);
        for (int unsigned k = steps; k != 0; k--)
        begin
            p = mt_state[i - 1];
            mix = (p ^ (p >> 30)) * 32'd1664525;
            mt_state[i] = (mt_state[i] ^ mix) + key_words[j] + j;
            i++;
            j++;
            if (i >= NW)
            begin
                mt_state[0] = mt_state[NW - 1];
                i = 1;
            end
            if (j >= cnt)
                j = 0;
        end
        for (int unsigned k = NW - 1; k != 0; k--)
        begin
            p = mt_state[i - 1];
            mix = (p ^ (p >> 30)) * 32'd1566083941;
            mt_state[i] = (mt_state[i] ^ mix) - i;
            i++;
            if (i >= NW)
            begin
                mt_state[0] = mt_state[NW - 1];
                i = 1;
            end
        end
        mt_state[0] = 32'h80000000;
        mt_pos = NW;
    endfunction

    function void regenerate();
        logic [31:0] y;
        for (int unsigned n = 0; n < NW; n++)
        begin
            y = (mt_state[n] & 32'h80000000) | (mt_state[(n + 1) % NW] & 32'h7fffffff);
            mt_state[n] = mt_state[(n + 397) % NW] ^ (y >> 1) ^ (y[0] ? 32'h9908b0df : 32'h0);
        end
        mt_pos = 0;
    endfunction

    function logic [31:0] next_word();
        logic [31:0] y;
        if (mt_pos >= NW)
        begin
            if (mt_pos != NW)
                init_single(32'd5489);   // draw before any seeding
            regenerate();
        end
        y = mt_state[mt_pos];
        mt_pos++;
        y ^= y >> 11;
        y ^= (y << 7) & 32'h9d2c5680;
        y ^= (y << 15) & 32'hefc60000;
        y ^= y >> 18;
        return y;
    endfunction

    assign pending = words_due.size();

    always @(posedge clk)
    begin
        logic [1:0]  op;
        logic [31:0] val;
        logic [31:0] want;
        if (!rst_n)
        begin
            mt_pos = UNSEEDED;
            key_n  = 0;
            errors = 0;
            words_due.delete();
        end
        else
        begin
            // result side first: a word accepted here cannot belong to an
            // input transaction taken at the same edge
            if (m_tvalid && m_tready)
            begin
                if (words_due.size() == 0)
                begin
                    $display("%0t: unexpected word: expected none, actual %08h",
                             $realtime, m_tdata);
                    errors++;
                end
                else
                begin
                    want = words_due.pop_front();
                    if (m_tdata !== want)
                    begin
                        $display("%0t: random_word mismatch: expected %08h, actual %08h",
                                 $realtime, want, m_tdata);
                        errors++;
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                op  = s_tdata[1:0];
                val = s_tdata[33:2];
                case (op)
                    mt_pkg::OP_DRAW: words_due = {words_due, next_word()};
                    mt_pkg::OP_SEED: init_single(val);
                    mt_pkg::OP_KEY:
                    begin
                        // words beyond the store are dropped
                        if (key_n < KEY_SLOTS)
                        begin
                            key_words[key_n] = val;
                            key_n++;
                        end
                        if (s_tlast)
                        begin
                            init_from_key(key_n);
                            key_n = 0;
                        end
                    end
                    default: ;   // unused code, ignored
                endcase
            end
        end
    end

endmodule

// ===== sim/mt19937_generator_tb.sv =====
// Testbench top for mt19937_generator: clock, reset, stimulus and verdict.
// Prediction and comparison live in mt19937_checker; depends on mt_pkg.
`timescale 1ns / 1ps

module mt19937_generator_tb;

    localparam logic [1:0] OP_SPARE = 2'd3;   // unused code, ignored by the block
    localparam int unsigned ITEM_GOAL = 1950;
    localparam int unsigned CALM_FROM = 1750;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;    // operation[1:0], value[33:2], zeros[39:34]
    logic        s_tlast;    // last_key
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;    // random_word[31:0]

    int          errors;
    int          pending;
    int unsigned items_sent;
    bit          calm;       // no idling on either side
    int unsigned stall_left;

    mt19937_generator u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    mt19937_checker u_checker (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .errors   (errors),
        .pending  (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Guard: seeding and twisting are slow, so allow plenty of headroom.
    initial
    begin
        #200_000_000;
        $display("** mt19937_generator: FAILED **");
        $finish;
    end

    // Receiver: random back-pressure bursts, steady ready once calm.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready   <= 1'b0;
            stall_left <= 0;
        end
        else if (calm)
            m_tready <= 1'b1;
        else if (stall_left != 0)
        begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if ($urandom_range(0, 7) == 0)
        begin
            m_tready   <= 1'b0;
            stall_left <= $urandom_range(0, 9);
        end
        else
            m_tready <= 1'b1;
    end

    // One input transaction; an idle burst may follow it.
    task automatic put(input logic [1:0] op, input logic [31:0] val, input logic lst);
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, val, op};
        s_tlast  <= lst;
        do
            @(posedge clk);
        while (!s_tready);
        if (op != OP_SPARE)
            items_sent++;
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
    endtask

    // A complete key: len words with the last one marked.
    task automatic put_key(input int unsigned len);
        for (int unsigned n = 1; n <= len; n++)
            put(mt_pkg::OP_KEY, $urandom(), n == len);
    endtask

    initial
    begin
        int unsigned pick;
        bit          drained;
        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tlast    = 1'b0;
        calm       = 1'b0;
        items_sent = 0;
        drained    = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // --- directed part ---
        put(mt_pkg::OP_DRAW, 32'hffffffff, 1'b1);   // draw before seeding, stray last mark
        put(mt_pkg::OP_DRAW, 32'h0, 1'b0);
        put(OP_SPARE, 32'hffffffff, 1'b1);          // unused code does nothing
        put(mt_pkg::OP_DRAW, 32'h0, 1'b0);
        put(mt_pkg::OP_SEED, 32'h0, 1'b1);          // zero seed, last mark ignored
        put(mt_pkg::OP_DRAW, 32'h0, 1'b0);
        put(mt_pkg::OP_SEED, 32'hffffffff, 1'b0);
        put(mt_pkg::OP_DRAW, 32'h0, 1'b0);
        put(mt_pkg::OP_KEY, 32'h0, 1'b1);           // single-word key of zero
        put(mt_pkg::OP_DRAW, 32'h0, 1'b0);
        // seed arriving mid-key leaves the collected words in place
        put(mt_pkg::OP_KEY, 32'hffffffff, 1'b0);
        put(mt_pkg::OP_SEED, 32'h12345678, 1'b0);
        put(mt_pkg::OP_KEY, 32'h00000001, 1'b1);
        put(mt_pkg::OP_DRAW, 32'h0, 1'b0);
        // overfull key: the dropped ninth word still starts seeding
        put_key(9);
        put(mt_pkg::OP_DRAW, 32'h0, 1'b0);

        // --- random part: mostly draw runs and whole keys, some noise ---
        while (items_sent < ITEM_GOAL)
        begin
            if (items_sent >= CALM_FROM)
                calm = 1'b1;
            if (!drained && items_sent >= ITEM_GOAL / 2)
            begin
                // hold the sender until every word has come back
                s_tvalid <= 1'b0;
                do
                    @(posedge clk);
                while (pending != 0);
                drained = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 70)
                repeat ($urandom_range(1, 40))
                    put(mt_pkg::OP_DRAW, $urandom(), $urandom_range(0, 1));
            else if (pick < 80)
                put(mt_pkg::OP_SEED, $urandom(), $urandom_range(0, 1));
            else if (pick < 92)
                put_key($urandom_range(1, 11));
            else if (pick < 96)
                put(mt_pkg::OP_KEY, $urandom(), 1'b0);    // key left open for later
            else
                put(OP_SPARE, $urandom(), $urandom_range(0, 1));
        end
        s_tvalid <= 1'b0;

        do
            @(posedge clk);
        while (pending != 0);
        // a trailing seed may still be running, such as an array seeding
        repeat (10000) @(posedge clk);

        if (errors == 0 && pending == 0)
            $display("** mt19937_generator: PASSED **");
        else
            $display("** mt19937_generator: FAILED **");
        $finish;
    end

endmodule

// ===== mt19937_generator.f =====
hdl/mt_pkg.sv
hdl/mt_datapath.sv
hdl/mt_control.sv
hdl/mt19937_generator.sv
sim/mt19937_checker.sv
sim/mt19937_generator_tb.sv
